[sv/tree_distance_lca_engine_defines.svh]
// Assertion macros shared by the checker.
`ifndef TREE_DISTANCE_LCA_ENGINE_DEFINES_SVH
`define TREE_DISTANCE_LCA_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TDL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TDL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/tdl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tdl_pkg;

  localparam int NODE_W = 10;
  localparam int NODES  = 1024;
  localparam int DIST_W = 11;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [DIST_W-1:0] dist_t;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam dist_t DIST_MAX  = '1;
  localparam node_t DEPTH_MAX = node_t'(NODES - 1);

endpackage

`default_nettype wire

[sv/tdl_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tdl_req_if;
  logic           valid;
  logic           ready;
  logic           action;
  tdl_pkg::node_t node_a;
  tdl_pkg::node_t node_b;

  modport source (output valid, action, node_a, node_b, input ready);
  modport sink   (input valid, action, node_a, node_b, output ready);
endinterface

interface tdl_rsp_if;
  logic           valid;
  logic           ready;
  tdl_pkg::dist_t distance;
  tdl_pkg::node_t common_ancestor;

  modport source (output valid, distance, common_ancestor, input ready);
  modport sink   (input valid, distance, common_ancestor, output ready);
endinterface

`default_nettype wire

[sv/tdl_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module tdl_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  output logic      [WIDTH-1:0]         rdata0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

[sv/tree_distance_lca_engine.sv]
// Add item: one table write per level; no new item is accepted until the top level is written.
// Add of node 0: dropped, ready again next cycle.
// Query item: no new item is taken until the result is registered; the joint lift is
//   skipped if the nodes meet; per level, serial ancestor-then-depth reads of both RAMs.
// Reset: synchronous; a clearing pass over the NODES*LEVELS table entries (10240 at
//   defaults) zeroes both RAMs before the first item is taken.
`timescale 1ns / 1ps
`default_nettype none

module tree_distance_lca_engine #(
  parameter int LEVELS = 10
) (
  input wire logic   clk,
  input wire logic   rst,
  tdl_req_if.sink    req,
  tdl_rsp_if.source  rsp
);

  localparam int NW  = tdl_pkg::NODE_W;
  localparam int LW  = $clog2(LEVELS);
  localparam int TD  = tdl_pkg::NODES * LEVELS;
  localparam int TAW = $clog2(TD);
  localparam int DW  = (LEVELS + 2 > 12) ? LEVELS + 2 : 12;

  localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ADEP  = 4'd2;
  localparam logic [3:0] S_ALVL  = 4'd3;
  localparam logic [3:0] S_QDEP  = 4'd4;
  localparam logic [3:0] S_QUP1  = 4'd5;
  localparam logic [3:0] S_QUP2  = 4'd6;
  localparam logic [3:0] S_QEQ   = 4'd7;
  localparam logic [3:0] S_QLIFT = 4'd8;
  localparam logic [3:0] S_QFIN  = 4'd9;
  localparam logic [3:0] S_QOUT  = 4'd10;

  function automatic logic [TAW-1:0] taddr(input tdl_pkg::node_t n, input logic [LW-1:0] l);
    taddr = TAW'(n) * TAW'(LEVELS) + TAW'(l);
  endfunction

  logic [3:0]     st;
  logic [TAW-1:0] clr;
  tdl_pkg::node_t a;
  tdl_pkg::node_t b;
  tdl_pkg::node_t x;
  tdl_pkg::node_t up;
  tdl_pkg::node_t da;
  logic [LW-1:0]  k;
  logic [DW-1:0]  hops;
  logic           res_valid;
  tdl_pkg::dist_t res_dist;
  tdl_pkg::node_t res_anc;

  logic           t_we;
  logic [TAW-1:0] t_wa;
  tdl_pkg::node_t t_wd;
  logic [TAW-1:0] t_ra0;
  logic [TAW-1:0] t_ra1;
  tdl_pkg::node_t rd_t0;
  tdl_pkg::node_t rd_t1;
  logic           d_we;
  tdl_pkg::node_t d_wa;
  tdl_pkg::node_t d_wd;
  tdl_pkg::node_t d_ra0;
  tdl_pkg::node_t d_ra1;
  tdl_pkg::node_t rd_d0;
  tdl_pkg::node_t rd_d1;

  logic           acc_in;
  tdl_pkg::node_t lift_src;
  tdl_pkg::node_t lift_v;
  logic [NW:0]    dinc;
  tdl_pkg::node_t d_sat;
  logic           swap;
  tdl_pkg::node_t qa;
  tdl_pkg::node_t qb;
  tdl_pkg::node_t qda;
  logic           take;
  tdl_pkg::node_t b_up;
  logic           diff;
  tdl_pkg::node_t a_l;
  tdl_pkg::node_t b_l;
  logic [LW-1:0]  lvl_up;
  logic [LW-1:0]  lvl_dn;
  tdl_pkg::dist_t dist_sat;

  tdl_ram #(.WIDTH(NW), .DEPTH(TD)) u_table (
    .clk    (clk),
    .we     (t_we),
    .waddr  (t_wa),
    .wdata  (t_wd),
    .raddr0 (t_ra0),
    .rdata0 (rd_t0),
    .raddr1 (t_ra1),
    .rdata1 (rd_t1)
  );

  tdl_ram #(.WIDTH(NW), .DEPTH(tdl_pkg::NODES)) u_depth (
    .clk    (clk),
    .we     (d_we),
    .waddr  (d_wa),
    .wdata  (d_wd),
    .raddr0 (d_ra0),
    .rdata0 (rd_d0),
    .raddr1 (d_ra1),
    .rdata1 (rd_d1)
  );

  assign req.ready           = (st == S_IDLE);
  assign acc_in              = req.valid && req.ready;
  assign rsp.valid           = res_valid;
  assign rsp.distance        = res_dist;
  assign rsp.common_ancestor = res_anc;

  // The row being filled is the only one written during an add: forward it.
  assign lift_src = (st == S_ADEP) ? b : x;
  assign lift_v   = (lift_src == a) ? lift_src : rd_t0;

  assign dinc  = {1'b0, rd_d0} + 1'b1;
  assign d_sat = (dinc > {1'b0, tdl_pkg::DEPTH_MAX}) ? tdl_pkg::DEPTH_MAX : dinc[NW-1:0];

  assign swap = (rd_d0 > rd_d1);
  assign qa   = swap ? b : a;
  assign qb   = swap ? a : b;
  assign qda  = swap ? rd_d1 : rd_d0;

  assign take = (rd_d0 >= da);
  assign b_up = take ? up : b;

  assign diff = (rd_t0 != rd_t1);
  assign a_l  = diff ? rd_t0 : a;
  assign b_l  = diff ? rd_t1 : b;

  assign lvl_up = (k == LVL_TOP) ? k : k + 1'b1;
  assign lvl_dn = (k == '0) ? k : k - 1'b1;

  assign dist_sat = (hops > DW'(tdl_pkg::DIST_MAX)) ? tdl_pkg::DIST_MAX
                                                    : hops[tdl_pkg::DIST_W-1:0];

  always_comb begin
    t_we  = 1'b0;
    t_wa  = clr;
    t_wd  = '0;
    t_ra0 = '0;
    t_ra1 = '0;
    d_we  = 1'b0;
    d_wa  = clr[NW-1:0];
    d_wd  = '0;
    d_ra0 = '0;
    d_ra1 = '0;
    case (st)
      S_CLEAR: begin
        t_we = 1'b1;
        d_we = (clr < TAW'(tdl_pkg::NODES));
      end
      S_IDLE: begin
        d_ra0 = (req.action == tdl_pkg::ACT_ADD) ? req.node_b : req.node_a;
        d_ra1 = req.node_b;
        t_ra0 = taddr(req.node_b, '0);
      end
      S_ADEP: begin
        d_we  = 1'b1;
        d_wa  = a;
        d_wd  = d_sat;
        t_we  = 1'b1;
        t_wa  = taddr(a, '0);
        t_wd  = b;
        t_ra0 = taddr(lift_v, LW'(1));
      end
      S_ALVL: begin
        t_we  = 1'b1;
        t_wa  = taddr(a, k);
        t_wd  = x;
        t_ra0 = taddr(lift_v, lvl_up);
      end
      S_QDEP: begin
        t_ra0 = taddr(qb, LVL_TOP);
      end
      S_QUP1: begin
        d_ra0 = rd_t0;
      end
      S_QUP2: begin
        t_ra0 = taddr(b_up, lvl_dn);
      end
      S_QEQ: begin
        t_ra0 = taddr(a, LVL_TOP);
        t_ra1 = taddr(b, LVL_TOP);
      end
      S_QLIFT: begin
        t_ra0 = taddr(a_l, lvl_dn);
        t_ra1 = taddr(b_l, lvl_dn);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_CLEAR;
      clr       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && st != S_QOUT) begin
        res_valid <= 1'b0;
      end
      case (st)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == TAW'(TD - 1)) begin
            st <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc_in) begin
            a <= req.node_a;
            b <= req.node_b;
            if (req.action == tdl_pkg::ACT_QUERY) begin
              st <= S_QDEP;
            end else if (req.node_a != '0) begin
              st <= S_ADEP;
            end
          end
        end
        S_ADEP: begin
          x  <= lift_v;
          k  <= LW'(1);
          st <= S_ALVL;
        end
        S_ALVL: begin
          if (k == LVL_TOP) begin
            st <= S_IDLE;
          end else begin
            x <= lift_v;
            k <= k + 1'b1;
          end
        end
        S_QDEP: begin
          a    <= qa;
          b    <= qb;
          da   <= qda;
          hops <= '0;
          k    <= LVL_TOP;
          st   <= S_QUP1;
        end
        S_QUP1: begin
          up <= rd_t0;
          st <= S_QUP2;
        end
        S_QUP2: begin
          b <= b_up;
          if (take) begin
            hops <= hops + (DW'(1) << k);
          end
          if (k == '0) begin
            st <= S_QEQ;
          end else begin
            k  <= k - 1'b1;
            st <= S_QUP1;
          end
        end
        S_QEQ: begin
          k <= LVL_TOP;
          if (a == b) begin
            st <= S_QOUT;
          end else begin
            st <= S_QLIFT;
          end
        end
        S_QLIFT: begin
          a <= a_l;
          b <= b_l;
          if (diff) begin
            hops <= hops + (DW'(2) << k);
          end
          if (k == '0) begin
            st <= S_QFIN;
          end else begin
            k <= k - 1'b1;
          end
        end
        S_QFIN: begin
          if (a != b) begin
            a    <= rd_t0;
            hops <= hops + DW'(2);
          end
          st <= S_QOUT;
        end
        S_QOUT: begin
          if (!res_valid || rsp.ready) begin
            res_valid <= 1'b1;
            res_dist  <= dist_sat;
            res_anc   <= a;
            st        <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/tdl_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "tree_distance_lca_engine_defines.svh"

module tdl_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_ready,
  input wire logic           req_action,
  input wire tdl_pkg::node_t req_node_a,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire tdl_pkg::dist_t rsp_distance,
  input wire tdl_pkg::node_t rsp_common_ancestor
);

  logic req_acc;
  assign req_acc = req_valid && req_ready;

  `TDL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_distance) && $stable(rsp_common_ancestor), "stalled result changed")
  `TDL_ASSERT_NEXT(a_busy_after_item, req_acc && (req_action == tdl_pkg::ACT_QUERY || req_node_a != '0), !req_ready, "ready stayed high after a working item")
  `TDL_ASSERT_NEXT(a_add_no_result, req_acc && req_action == tdl_pkg::ACT_ADD && !rsp_valid, !rsp_valid, "add item raised a result")
  `TDL_ASSERT_NOW(a_clear_after_reset, $fell(rst), !req_ready && !rsp_valid, "item channel open during clearing pass")

endmodule

bind tree_distance_lca_engine tdl_checker u_tdl_checker (
  .clk                 (clk),
  .rst                 (rst),
  .req_valid           (req.valid),
  .req_ready           (req.ready),
  .req_action          (req.action),
  .req_node_a          (req.node_a),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_distance        (rsp.distance),
  .rsp_common_ancestor (rsp.common_ancestor)
);

`default_nettype wire

[dv/tb_tree_distance_lca_engine.sv]
`timescale 1ns / 1ps

module tb_tree_distance_lca_engine;

  localparam int LIFT_LEVELS  = 10;
  localparam int RANDOM_ITEMS = 740;
  localparam int SAT_ADDS     = 1030;

  typedef struct packed {
    tdl_pkg::dist_t distance;
    tdl_pkg::node_t common_ancestor;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   calm = 1'b0;

  tdl_req_if req ();
  tdl_rsp_if rsp ();

  tree_distance_lca_engine #(.LEVELS(LIFT_LEVELS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #1 clk = ~clk;

  bit [tdl_pkg::NODE_W-1:0] depth_of [tdl_pkg::NODES];
  bit [tdl_pkg::NODE_W-1:0] lift_of [tdl_pkg::NODES][LIFT_LEVELS];
  reply_t                   pending_replies [$];
  int                       errors = 0;
  int                       adds_sent = 0;
  int                       queries_sent = 0;
  int                       replies_checked = 0;

  function automatic void tree_add(tdl_pkg::node_t u, tdl_pkg::node_t p);
    int unsigned d;
    if (u == '0) return;
    d = depth_of[p] + 1;
    if (d > tdl_pkg::DEPTH_MAX) d = tdl_pkg::DEPTH_MAX;
    depth_of[u] = tdl_pkg::node_t'(d);
    lift_of[u][0] = p;
    for (int k = 1; k < LIFT_LEVELS; k++) lift_of[u][k] = lift_of[lift_of[u][k-1]][k-1];
  endfunction

  function automatic reply_t tree_query(tdl_pkg::node_t a, tdl_pkg::node_t b);
    int unsigned    hops;
    tdl_pkg::node_t t;
    tdl_pkg::node_t ua;
    tdl_pkg::node_t ub;
    reply_t         r;
    hops = 0;
    if (depth_of[a] > depth_of[b]) begin
      t = a;
      a = b;
      b = t;
    end
    for (int k = LIFT_LEVELS - 1; k >= 0; k--) begin
      ub = lift_of[b][k];
      if (depth_of[ub] >= depth_of[a]) begin
        b = ub;
        hops += 1 << k;
      end
    end
    if (a != b) begin
      for (int k = LIFT_LEVELS - 1; k >= 0; k--) begin
        ua = lift_of[a][k];
        ub = lift_of[b][k];
        if (ua != ub) begin
          a = ua;
          b = ub;
          hops += 1 << (k + 1);
        end
      end
      if (a != b) begin
        a = lift_of[a][0];
        hops += 2;
      end
    end
    if (hops > tdl_pkg::DIST_MAX) hops = tdl_pkg::DIST_MAX;
    r.distance = tdl_pkg::dist_t'(hops);
    r.common_ancestor = a;
    return r;
  endfunction

  always @(posedge clk) begin
    rsp.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 26);
  end

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply distance %0d ancestor %0d", $time,
                 rsp.distance, rsp.common_ancestor);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        replies_checked++;
        if (rsp.distance !== want.distance) begin
          $display("%0t: distance mismatch expected %0d actual %0d", $time,
                   want.distance, rsp.distance);
          errors++;
        end
        if (rsp.common_ancestor !== want.common_ancestor) begin
          $display("%0t: ancestor mismatch expected %0d actual %0d", $time,
                   want.common_ancestor, rsp.common_ancestor);
          errors++;
        end
      end
    end
  end

  task automatic send_item(logic act, tdl_pkg::node_t a, tdl_pkg::node_t b);
    if (!calm && $urandom_range(0, 99) < 26) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req.valid  <= 1'b1;
    req.action <= act;
    req.node_a <= a;
    req.node_b <= b;
    do @(posedge clk); while (!req.ready);
    if (act == tdl_pkg::ACT_ADD) begin
      tree_add(a, b);
      adds_sent++;
    end else begin
      pending_replies.insert(pending_replies.size(), tree_query(a, b));
      queries_sent++;
    end
  endtask

  task automatic test_directed();
    send_item(tdl_pkg::ACT_QUERY, 10'd0, 10'd0);
    send_item(tdl_pkg::ACT_QUERY, 10'd1023, 10'd1);
    send_item(tdl_pkg::ACT_ADD, 10'd0, 10'd5);
    send_item(tdl_pkg::ACT_QUERY, 10'd0, 10'd5);
    send_item(tdl_pkg::ACT_ADD, 10'd1, 10'd0);
    send_item(tdl_pkg::ACT_ADD, 10'd2, 10'd1);
    send_item(tdl_pkg::ACT_ADD, 10'd3, 10'd1);
    send_item(tdl_pkg::ACT_ADD, 10'd1023, 10'd2);
    send_item(tdl_pkg::ACT_ADD, 10'd512, 10'd3);
    send_item(tdl_pkg::ACT_ADD, 10'd4, 10'd1023);
    send_item(tdl_pkg::ACT_QUERY, 10'd4, 10'd512);
    send_item(tdl_pkg::ACT_QUERY, 10'd512, 10'd4);
    send_item(tdl_pkg::ACT_QUERY, 10'd1, 10'd1);
    send_item(tdl_pkg::ACT_QUERY, 10'd1023, 10'd1);
    send_item(tdl_pkg::ACT_QUERY, 10'd4, 10'd0);
    send_item(tdl_pkg::ACT_QUERY, 10'd2, 10'd3);
    send_item(tdl_pkg::ACT_ADD, 10'd9, 10'd600);
    send_item(tdl_pkg::ACT_QUERY, 10'd9, 10'd4);
    send_item(tdl_pkg::ACT_ADD, 10'd700, 10'd700);
    send_item(tdl_pkg::ACT_ADD, 10'd701, 10'd701);
    send_item(tdl_pkg::ACT_QUERY, 10'd700, 10'd701);
    send_item(tdl_pkg::ACT_QUERY, 10'd1023, 10'd1022);
  endtask

  task automatic test_depth_saturation();
    calm = 1'b1;
    repeat (SAT_ADDS) send_item(tdl_pkg::ACT_ADD, 10'd900, 10'd900);
    send_item(tdl_pkg::ACT_ADD, 10'd901, 10'd900);
    send_item(tdl_pkg::ACT_QUERY, 10'd900, 10'd1);
    send_item(tdl_pkg::ACT_QUERY, 10'd901, 10'd900);
    send_item(tdl_pkg::ACT_QUERY, 10'd700, 10'd901);
    calm = 1'b0;
  endtask

  task automatic test_random_trees();
    tdl_pkg::node_t members [$];
    bit             in_round [tdl_pkg::NODES];
    tdl_pkg::node_t u;
    tdl_pkg::node_t p;
    tdl_pkg::node_t qa;
    tdl_pkg::node_t qb;
    int             adds_left;
    int             queries_left;
    int             chain_pct;
    int             sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      members.delete();
      foreach (in_round[i]) in_round[i] = 1'b0;
      adds_left = $urandom_range(8, 160);
      queries_left = $urandom_range(adds_left / 2, adds_left);
      chain_pct = $urandom_range(30, 95);
      while (adds_left + queries_left > 0 && sent < RANDOM_ITEMS) begin
        if ($urandom_range(0, 99) < 8) begin
          send_item(1'($urandom_range(0, 1)), tdl_pkg::node_t'($urandom_range(0, 1023)),
                    tdl_pkg::node_t'($urandom_range(0, 1023)));
        end else if (adds_left > 0 &&
                     (members.size() < 2 || queries_left == 0 || $urandom_range(0, 1))) begin
          do u = tdl_pkg::node_t'($urandom_range(1, 1023)); while (in_round[u]);
          if (members.size() == 0 || $urandom_range(0, 19) == 0) p = '0;
          else if ($urandom_range(0, 99) < chain_pct) p = members[members.size() - 1];
          else p = members[$urandom_range(0, members.size() - 1)];
          send_item(tdl_pkg::ACT_ADD, u, p);
          members.insert(members.size(), u);
          in_round[u] = 1'b1;
          adds_left--;
        end else begin
          qa = members[$urandom_range(0, members.size() - 1)];
          qb = ($urandom_range(0, 9) == 0) ? tdl_pkg::node_t'(0) :
               members[$urandom_range(0, members.size() - 1)];
          send_item(tdl_pkg::ACT_QUERY, qa, qb);
          queries_left--;
        end
        sent++;
      end
    end
  endtask

  initial begin
    req.valid  <= 1'b0;
    req.action <= tdl_pkg::ACT_ADD;
    req.node_a <= '0;
    req.node_b <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_depth_saturation();
    test_random_trees();
    req.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d adds and %0d queries, %0d replies checked", adds_sent,
             queries_sent, replies_checked);
    $display("incl. ignored sentinel adds, unknown nodes, depth clamp and distance clamp");
    if (errors == 0) $display("tb_tree_distance_lca_engine: clean");
    else $display("tb_tree_distance_lca_engine: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_tree_distance_lca_engine: errors");
    $finish;
  end

endmodule
